FILE: rtl/muart_pkg.sv
// Shared types and constants for the multi-channel UART.
`default_nettype none

package muart_pkg;

  // Port field widths
  localparam int FUNC_W    = 2;
  localparam int CHAN_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int LINES_W   = 3;
  localparam int CNT_W     = 5;
  localparam int CNT_MAX   = 31;
  localparam int BITS_W    = 4;
  localparam int FRAME_BITS = 8;

  // Configuration
  localparam int CFG_IDX_W  = 2;
  localparam int PERIOD_W   = 16;
  localparam int ENABLE_W   = 3;
  localparam int CFG_CH     = 3;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD_C = 2'd3;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

  // Frame phase of a receiver or transmitter
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  // Per-channel control from the top level
  typedef struct packed {
    logic                step;
    logic                enabled;
    logic [PERIOD_W-1:0] period;
  } chan_ctl_t;

  // Receiver status for one step
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
  } rx_stat_t;

  // Transmitter status after one step
  typedef struct packed {
    logic level;
    logic busy;
    logic accepted;
  } tx_stat_t;

endpackage

`default_nettype wire

FILE: rtl/multi_channel_uart.sv
// Top level of the multi-channel 8N1 UART with per-channel receive FIFOs.
// Usage:
//   Each request on the in_ channel is one sampling tick of all serial lines:
//   in_rx_lines carries the receive levels, and in_func may add a FIFO read
//   (pop) or a transmit write for the channel in in_channel.
//   Each request gives exactly one result on the out_ channel: transmit line
//   levels, busy and drop flags per channel, the popped byte, the write
//   acceptance and the byte count left in the addressed FIFO.
//   An accepted request is held in the input register while it is processed,
//   and its result is then loaded into the result register.
//   Throughput: one request per cycle while results are taken; the per-channel
//   receiver, transmitter and FIFO pointer logic all finish within one processing step.
//   When out_ready is low the result register holds, the input register keeps
//   one more request, and in_ready drops once both are full.
//   The cfg_ port writes enable_mask and the three bit periods; write it only
//   while no request is in flight.
//   Reset (synchronous, rst_n low) idles all receivers and transmitters,
//   empties the FIFOs and restores enable_mask 0 and periods of 104 ticks.
//   The FIFO storage itself needs no clearing; there is no start-up pass.
`default_nettype none

module multi_channel_uart #(
  parameter int NUM_CHANNELS = 3,
  parameter int FIFO_DEPTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration
  input  wire logic                                cfg_wr_en,
  input  wire logic [muart_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [muart_pkg::PERIOD_W-1:0]      cfg_wr_data,
  // Request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [muart_pkg::FUNC_W-1:0]        in_func,
  input  wire logic [muart_pkg::CHAN_W-1:0]        in_channel,
  input  wire logic [muart_pkg::BYTE_W-1:0]        in_wr_data,
  input  wire logic [muart_pkg::LINES_W-1:0]       in_rx_lines,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [muart_pkg::LINES_W-1:0]       out_tx_lines,
  output logic                                     out_read_valid,
  output logic      [muart_pkg::BYTE_W-1:0]        out_read_data,
  output logic      [muart_pkg::CNT_W-1:0]         out_rx_count,
  output logic                                     out_write_accepted,
  output logic      [muart_pkg::LINES_W-1:0]       out_tx_busy,
  output logic      [muart_pkg::LINES_W-1:0]       out_rx_dropped
);

  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int CW  = PW + 1;
  localparam int EW  = (CW > muart_pkg::CNT_W) ? CW : muart_pkg::CNT_W;
  localparam int DW  = muart_pkg::BYTE_W;
  localparam int LW  = muart_pkg::LINES_W;
  localparam int TW  = muart_pkg::PERIOD_W;
  localparam int NW  = muart_pkg::CNT_W;

  // Configuration registers
  logic [muart_pkg::ENABLE_W-1:0] enable_mask_r;
  logic [TW-1:0]                  period_r [muart_pkg::CFG_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r <= '0;
      period_r[0]   <= muart_pkg::PERIOD_RESET;
      period_r[1]   <= muart_pkg::PERIOD_RESET;
      period_r[2]   <= muart_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        muart_pkg::CFG_ENABLE_MASK:  enable_mask_r <= cfg_wr_data[muart_pkg::ENABLE_W-1:0];
        muart_pkg::CFG_BIT_PERIOD_A: period_r[0]   <= cfg_wr_data;
        muart_pkg::CFG_BIT_PERIOD_B: period_r[1]   <= cfg_wr_data;
        muart_pkg::CFG_BIT_PERIOD_C: period_r[2]   <= cfg_wr_data;
      endcase
    end
  end

  // Handshake control
  logic s1_vld_r;
  logic out_valid_r;
  logic fire;
  logic load;

  assign fire     = s1_vld_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_vld_r | fire;
  assign load     = in_valid & in_ready;

  // Input register
  logic [muart_pkg::FUNC_W-1:0] s1_func_r;
  logic [muart_pkg::CHAN_W-1:0] s1_channel_r;
  logic [DW-1:0]                s1_wr_data_r;
  logic [LW-1:0]                s1_rx_lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_func_r     <= in_func;
      s1_channel_r  <= in_channel;
      s1_wr_data_r  <= in_wr_data;
      s1_rx_lines_r <= in_rx_lines;
    end
  end

  logic is_read;
  logic is_write;

  assign is_read  = (s1_func_r == muart_pkg::FUNC_READ);
  assign is_write = (s1_func_r == muart_pkg::FUNC_WRITE);

  // Per-channel results
  logic [NUM_CHANNELS-1:0] sel_vec;
  logic [NUM_CHANNELS-1:0] pop_vec;
  logic [NUM_CHANNELS-1:0] acc_vec;
  logic [NUM_CHANNELS-1:0] drop_vec;
  logic [DW-1:0]           pop_data_a [NUM_CHANNELS];
  logic [NW-1:0]           cnt_a      [NUM_CHANNELS];
  muart_pkg::rx_stat_t     rx_st      [NUM_CHANNELS];
  muart_pkg::tx_stat_t     tx_st      [NUM_CHANNELS];

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    localparam int PSEL = (c < muart_pkg::CFG_CH) ? c : muart_pkg::CFG_CH - 1;

    muart_pkg::chan_ctl_t ctl;
    logic                 line;
    logic                 enabled;
    logic [TW-1:0]        period_raw;
    logic [PW-1:0]        head_r, tail_r, head_nxt, tail_nxt;
    logic [PW-1:0]        head_inc, tail_inc, head_after, tail_after;
    logic                 full;
    logic                 wr_en;
    logic [DW-1:0]        rd_q;
    logic [CW-1:0]        diff;
    logic [EW-1:0]        diff_ext;

    // Channels beyond the enable mask stay disabled
    if (c < muart_pkg::CFG_CH) begin : g_cfg
      assign enabled = enable_mask_r[c];
      assign line    = s1_rx_lines_r[c];
    end else begin : g_nocfg
      assign enabled = 1'b0;
      assign line    = 1'b0;
    end

    assign period_raw  = period_r[PSEL];
    assign ctl.step    = fire;
    assign ctl.enabled = enabled;
    assign ctl.period  = (period_raw < muart_pkg::PERIOD_MIN) ? muart_pkg::PERIOD_MIN
                                                                : period_raw;

    assign sel_vec[c] = ({2'b00, s1_channel_r} == 4'(c));

    muart_rx u_rx (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .line  (line),
      .stat  (rx_st[c])
    );

    muart_tx u_tx (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_req  (is_write & sel_vec[c]),
      .wr_data (s1_wr_data_r),
      .stat    (tx_st[c])
    );

    // Ring pointers: push first, then pop
    assign head_inc   = (head_r == PW'(FIFO_DEPTH - 1)) ? '0 : head_r + PW'(1);
    assign tail_inc   = (tail_r == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r + PW'(1);
    assign full       = (head_inc == tail_r);
    assign wr_en      = rx_st[c].push & ~full;
    assign drop_vec[c] = rx_st[c].push & full;
    assign head_after = wr_en ? head_inc : head_r;
    assign pop_vec[c] = is_read & sel_vec[c] & (head_after != tail_r);
    assign tail_after = pop_vec[c] ? tail_inc : tail_r;
    assign head_nxt   = fire ? head_after : head_r;
    assign tail_nxt   = fire ? tail_after : tail_r;

    // A byte pushed into an empty FIFO is popped straight from the receiver
    assign pop_data_a[c] = (wr_en && (head_r == tail_r)) ? rx_st[c].data : rd_q;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r <= '0;
        tail_r <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
    end

    muart_mem #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (DW)
    ) u_mem (
      .clk   (clk),
      .we    (fire & wr_en),
      .waddr (head_r),
      .wdata (rx_st[c].data),
      .re    (load),
      .raddr (tail_nxt),
      .rdata (rd_q)
    );

    // Fill level after the step, saturated
    always_comb begin
      diff = CW'(head_after) - CW'(tail_after);
      if (head_after < tail_after) begin
        diff = diff + CW'(FIFO_DEPTH);
      end
      diff_ext = EW'(diff);
      cnt_a[c] = (diff_ext > EW'(muart_pkg::CNT_MAX)) ? NW'(muart_pkg::CNT_MAX)
                                                      : NW'(diff_ext);
    end

    assign acc_vec[c] = tx_st[c].accepted;
  end

  // Pick the addressed channel
  logic          read_valid_nxt;
  logic [DW-1:0] read_data_nxt;
  logic [NW-1:0] rx_count_nxt;
  logic          write_acc_nxt;

  always_comb begin
    read_valid_nxt = |pop_vec;
    write_acc_nxt  = |acc_vec;
    read_data_nxt  = '0;
    rx_count_nxt   = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (pop_vec[c]) begin
        read_data_nxt = read_data_nxt | pop_data_a[c];
      end
      if (sel_vec[c]) begin
        rx_count_nxt = rx_count_nxt | cnt_a[c];
      end
    end
  end

  // Per-line flags, zero for lines without a channel
  logic [LW-1:0] tx_lines_nxt;
  logic [LW-1:0] tx_busy_nxt;
  logic [LW-1:0] rx_dropped_nxt;

  for (genvar b = 0; b < LW; b++) begin : g_line
    if (b < NUM_CHANNELS) begin : g_on
      assign tx_lines_nxt[b]   = tx_st[b].level;
      assign tx_busy_nxt[b]    = tx_st[b].busy;
      assign rx_dropped_nxt[b] = drop_vec[b];
    end else begin : g_off
      assign tx_lines_nxt[b]   = 1'b0;
      assign tx_busy_nxt[b]    = 1'b0;
      assign rx_dropped_nxt[b] = 1'b0;
    end
  end

  // Result register
  logic [LW-1:0] tx_lines_r;
  logic          read_valid_r;
  logic [DW-1:0] read_data_r;
  logic [NW-1:0] rx_count_r;
  logic          write_acc_r;
  logic [LW-1:0] tx_busy_r;
  logic [LW-1:0] rx_dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_lines_r   <= tx_lines_nxt;
      read_valid_r <= read_valid_nxt;
      read_data_r  <= read_data_nxt;
      rx_count_r   <= rx_count_nxt;
      write_acc_r  <= write_acc_nxt;
      tx_busy_r    <= tx_busy_nxt;
      rx_dropped_r <= rx_dropped_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_lines       = tx_lines_r;
  assign out_read_valid     = read_valid_r;
  assign out_read_data      = read_data_r;
  assign out_rx_count       = rx_count_r;
  assign out_write_accepted = write_acc_r;
  assign out_tx_busy        = tx_busy_r;
  assign out_rx_dropped     = rx_dropped_r;

  // Checks
  a_one_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> $onehot0(pop_vec))
    else $error("more than one FIFO popped in one step");

  a_read_or_write: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(read_valid_nxt && write_acc_nxt))
    else $error("read and write served in the same step");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(read_data_r)
                                     && $stable(rx_count_r)))
    else $error("pending result lost or changed");

  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !read_valid_r) |-> (read_data_r == '0))
    else $error("read data not zero on empty or absent read");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_valid_r && !out_ready))
    else $error("request channel stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: rtl/muart_mem.sv
// Receive FIFO storage for one channel: one write port, one registered read port.
`default_nettype none

module muart_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, new data forwarded on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/muart_rx.sv
// 8N1 receiver for one channel: start qualification, data sampling, stop wait.
`default_nettype none

module muart_rx (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire muart_pkg::chan_ctl_t ctl,
  input  wire logic                 line,
  output muart_pkg::rx_stat_t       stat
);

  localparam int TW = muart_pkg::PERIOD_W;
  localparam int BW = muart_pkg::BITS_W;
  localparam int DW = muart_pkg::BYTE_W;

  muart_pkg::phase_t phase_r, phase_nxt;
  logic [BW-1:0]     bits_r, bits_nxt;
  logic [TW-1:0]     timer_r, timer_nxt;
  logic [DW-1:0]     shift_r, shift_nxt;
  logic              push;

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    push      = 1'b0;
    if (!ctl.enabled) begin
      phase_nxt = muart_pkg::PH_IDLE;
      timer_nxt = '0;
      bits_nxt  = '0;
    end else if (phase_r == muart_pkg::PH_IDLE) begin
      if (!line) begin
        phase_nxt = muart_pkg::PH_START;
        timer_nxt = ctl.period >> 1;
      end
    end else if (timer_r > TW'(1)) begin
      timer_nxt = timer_r - TW'(1);
    end else begin
      timer_nxt = ctl.period;
      unique case (phase_r)
        muart_pkg::PH_START: begin
          if (line) begin
            phase_nxt = muart_pkg::PH_IDLE;
          end else begin
            phase_nxt = muart_pkg::PH_DATA;
            bits_nxt  = '0;
            shift_nxt = '0;
          end
        end
        muart_pkg::PH_DATA: begin
          if (line) begin
            shift_nxt = shift_r | (DW'(1) << bits_r[2:0]);
          end
          bits_nxt = bits_r + BW'(1);
          if (bits_nxt >= BW'(muart_pkg::FRAME_BITS)) begin
            phase_nxt = muart_pkg::PH_STOP;
          end
        end
        muart_pkg::PH_STOP: begin
          phase_nxt = muart_pkg::PH_IDLE;
          push      = 1'b1;
        end
        muart_pkg::PH_IDLE: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // State registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= muart_pkg::PH_IDLE;
      bits_r  <= '0;
      timer_r <= '0;
      shift_r <= '0;
    end else if (ctl.step) begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
    end
  end

  assign stat.push = push;
  assign stat.data = shift_r;

endmodule

`default_nettype wire

FILE: rtl/muart_tx.sv
// 8N1 transmitter for one channel: bit timing, frame start on a write.
`default_nettype none

module muart_tx (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire muart_pkg::chan_ctl_t              ctl,
  input  wire logic                              wr_req,
  input  wire logic [muart_pkg::BYTE_W-1:0]      wr_data,
  output muart_pkg::tx_stat_t                    stat
);

  localparam int TW = muart_pkg::PERIOD_W;
  localparam int BW = muart_pkg::BITS_W;
  localparam int DW = muart_pkg::BYTE_W;

  muart_pkg::phase_t phase_r, phase_nxt, phase_adv;
  logic [BW-1:0]     bits_r, bits_nxt, bits_adv;
  logic [TW-1:0]     timer_r, timer_nxt, timer_adv;
  logic [DW-1:0]     shift_r, shift_nxt;
  logic              accepted;

  // Bit timing for one tick
  always_comb begin
    phase_adv = phase_r;
    bits_adv  = bits_r;
    timer_adv = timer_r;
    if (!ctl.enabled) begin
      phase_adv = muart_pkg::PH_IDLE;
      timer_adv = '0;
      bits_adv  = '0;
    end else if (phase_r == muart_pkg::PH_IDLE) begin
      phase_adv = phase_r;
    end else if (timer_r > TW'(1)) begin
      timer_adv = timer_r - TW'(1);
    end else begin
      timer_adv = ctl.period;
      unique case (phase_r)
        muart_pkg::PH_START: begin
          phase_adv = muart_pkg::PH_DATA;
          bits_adv  = '0;
        end
        muart_pkg::PH_DATA: begin
          bits_adv = bits_r + BW'(1);
          if (bits_adv >= BW'(muart_pkg::FRAME_BITS)) begin
            phase_adv = muart_pkg::PH_STOP;
          end
        end
        muart_pkg::PH_STOP: begin
          phase_adv = muart_pkg::PH_IDLE;
        end
        muart_pkg::PH_IDLE: begin
          phase_adv = phase_r;
        end
      endcase
    end
  end

  // Write request starts a frame on an idle, enabled channel
  always_comb begin
    phase_nxt = phase_adv;
    bits_nxt  = bits_adv;
    timer_nxt = timer_adv;
    shift_nxt = shift_r;
    accepted  = 1'b0;
    if (wr_req && ctl.enabled && (phase_adv == muart_pkg::PH_IDLE)) begin
      phase_nxt = muart_pkg::PH_START;
      bits_nxt  = '0;
      timer_nxt = ctl.period;
      shift_nxt = wr_data;
      accepted  = 1'b1;
    end
  end

  // Line level and busy flag after the tick
  always_comb begin
    stat.accepted = accepted;
    stat.busy     = (phase_nxt != muart_pkg::PH_IDLE);
    unique case (phase_nxt)
      muart_pkg::PH_START: stat.level = 1'b0;
      muart_pkg::PH_DATA:  stat.level = shift_nxt[bits_nxt[2:0]];
      muart_pkg::PH_IDLE,
      muart_pkg::PH_STOP:  stat.level = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= muart_pkg::PH_IDLE;
      bits_r  <= '0;
      timer_r <= '0;
      shift_r <= '0;
    end else if (ctl.step) begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

`default_nettype wire
